// ===== sv/plcg_pkg.sv =====
// ----------------------------------------------------------------------------
// plcg_pkg: shared types and constants of the particle link contact generator
// Beat layouts between the front, the middle queue and the back pipeline.
// ----------------------------------------------------------------------------
package plcg_pkg;

  localparam int MQ_DEPTH    = 8;   // middle queue, power of two
  localparam int OQ_DEPTH    = 32;  // result queue, power of two
  localparam int SQRT_STAGES = 16;  // two root bits per stage
  localparam int DIV_STAGES  = 8;   // two quotient bits per stage
  localparam int NORMAL_ONE  = 16384;

  localparam logic [2:0] REG_LINK_KIND     = 3'd0;
  localparam logic [2:0] REG_ANCHORED      = 3'd1;
  localparam logic [2:0] REG_LINK_LENGTH   = 3'd2;
  localparam logic [2:0] REG_BOUNCE_FACTOR = 3'd3;
  localparam logic [2:0] REG_ANCHOR_X      = 3'd4;
  localparam logic [2:0] REG_ANCHOR_Y      = 3'd5;
  localparam logic [2:0] REG_ANCHOR_Z      = 3'd6;

  // front -> back: magnitudes and signs of the link vector and its square norm
  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] mx;
    logic [31:0] my;
    logic [31:0] mz;
    logic        sx;
    logic        sy;
    logic        sz;
    logic [63:0] sum;
  } front_beat_t;

  typedef struct packed {
    logic [7:0]         tag;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [31:0]        depth;
    logic [15:0]        rest;
    logic               anch;
  } result_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [35:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [47:0] r;
    logic [15:0] q;
  } div_st_t;

  // two digit-by-digit square root iterations
  function automatic sqrt_st_t sqrt_step2(input sqrt_st_t s);
    sqrt_st_t   o;
    logic [35:0] r;
    logic [35:0] trial;
    o = s;
    for (int i = 0; i < 2; i++) begin
      r     = {o.rem[33:0], o.rad[63:62]};
      trial = {2'b00, o.root, 2'b01};
      o.rad = {o.rad[61:0], 2'b00};
      if (r >= trial) begin
        o.rem  = r - trial;
        o.root = {o.root[30:0], 1'b1};
      end else begin
        o.rem  = r;
        o.root = {o.root[30:0], 1'b0};
      end
    end
    return o;
  endfunction

  // two restoring division steps for quotient bits k and k-1
  function automatic div_st_t div_step2(input div_st_t s, input logic [31:0] d, input int k);
    div_st_t     o;
    logic [47:0] trial;
    o = s;
    for (int i = 0; i < 2; i++) begin
      trial = {16'h0, d} << (k - i);
      if (o.r >= trial) begin
        o.r = o.r - trial;
        o.q = {o.q[14:0], 1'b1};
      end else begin
        o.q = {o.q[14:0], 1'b0};
      end
    end
    return o;
  endfunction

  // saturate to one and apply the sign; a zero length gives zero
  function automatic logic [15:0] finish_comp(input logic [15:0] q, input logic neg,
                                              input logic zero);
    logic [15:0] m;
    m = (q > 16'(NORMAL_ONE)) ? 16'(NORMAL_ONE) : q;
    if (zero) return 16'h0;
    return neg ? (16'h0 - m) : m;
  endfunction

endpackage

// ===== sv/particle_link_contact_generator_unit.sv =====
// ----------------------------------------------------------------------------
// particle_link_contact_generator_unit: cable and rod contact generation
// One link per beat in, zero or one contact per link out, in input order.
// ----------------------------------------------------------------------------
// Takes one link per clock while full is low. The front forms the link vector
// (second end minus first, the second end being the anchor registers when
// anchored) and its squared length in three stages, then drops the beat into
// an 8-entry queue. The back pipeline takes the floor square root (16 stages,
// two root bits each), decides the contact, and divides each component by the
// length for a rounded Q1.14 normal (8 stages, two quotient bits each).
// Throughput is one link per cycle as long as pop keeps up. The back reserves
// a slot in the 32-entry result queue for every link it starts, so full rises
// only when results are not being drained. Cables report when length >=
// link_length; rods whenever the length differs, with the normal flipped when
// compressed. Coincident ends give a zero normal. Write configuration only
// while the block is idle.
// ----------------------------------------------------------------------------
module particle_link_contact_generator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         link_tag,
  input  logic signed [30:0] first_x,
  input  logic signed [30:0] first_y,
  input  logic signed [30:0] first_z,
  input  logic signed [30:0] second_x,
  input  logic signed [30:0] second_y,
  input  logic signed [30:0] second_z,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         contact_tag,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic [31:0]        depth,
  output logic [15:0]        contact_restitution,
  output logic               against_anchor,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  // configuration registers
  logic               link_kind;
  logic               anchored;
  logic [31:0]        link_length;
  logic [15:0]        bounce_factor;
  logic signed [30:0] anchor_x;
  logic signed [30:0] anchor_y;
  logic signed [30:0] anchor_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_kind     <= 1'b0;
      anchored      <= 1'b0;
      link_length   <= '0;
      bounce_factor <= '0;
      anchor_x      <= '0;
      anchor_y      <= '0;
      anchor_z      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        plcg_pkg::REG_LINK_KIND:     link_kind     <= cfg_data[0];
        plcg_pkg::REG_ANCHORED:      anchored      <= cfg_data[0];
        plcg_pkg::REG_LINK_LENGTH:   link_length   <= cfg_data;
        plcg_pkg::REG_BOUNCE_FACTOR: bounce_factor <= cfg_data[15:0];
        plcg_pkg::REG_ANCHOR_X:      anchor_x      <= cfg_data[30:0];
        plcg_pkg::REG_ANCHOR_Y:      anchor_y      <= cfg_data[30:0];
        plcg_pkg::REG_ANCHOR_Z:      anchor_z      <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // front -> middle queue
  logic                                    fb_valid;
  plcg_pkg::front_beat_t                   fb;
  logic [$clog2(plcg_pkg::MQ_DEPTH+1)-1:0] mq_count;
  logic                                    mq_empty;
  logic                                    mq_pop;
  plcg_pkg::front_beat_t                   mq_data;

  plcg_front u_front (
    .clk, .rst, .push, .full, .link_tag,
    .first_x, .first_y, .first_z, .second_x, .second_y, .second_z,
    .anchored, .anchor_x, .anchor_y, .anchor_z,
    .mq_count, .beat_valid(fb_valid), .beat(fb)
  );

  plcg_fifo #(
    .WIDTH($bits(plcg_pkg::front_beat_t)),
    .DEPTH(plcg_pkg::MQ_DEPTH)
  ) u_mid_q (
    .clk, .rst, .push(fb_valid), .wdata(fb), .pop(mq_pop),
    .rdata(mq_data), .empty(mq_empty), .count(mq_count)
  );

  // back -> result queue
  logic                                    oq_push;
  plcg_pkg::result_t                       oq_wdata;
  plcg_pkg::result_t                       oq_rdata;
  logic [$clog2(plcg_pkg::OQ_DEPTH+1)-1:0] oq_count;

  plcg_back u_back (
    .clk, .rst, .mq_empty, .mq_data, .mq_pop, .oq_count,
    .oq_push, .oq_data(oq_wdata),
    .link_kind, .anchored, .link_length, .bounce_factor
  );

  plcg_fifo #(
    .WIDTH($bits(plcg_pkg::result_t)),
    .DEPTH(plcg_pkg::OQ_DEPTH)
  ) u_res_q (
    .clk, .rst, .push(oq_push), .wdata(oq_wdata), .pop,
    .rdata(oq_rdata), .empty, .count(oq_count)
  );

  assign contact_tag         = oq_rdata.tag;
  assign normal_x            = oq_rdata.nx;
  assign normal_y            = oq_rdata.ny;
  assign normal_z            = oq_rdata.nz;
  assign depth               = oq_rdata.depth;
  assign contact_restitution = oq_rdata.rest;
  assign against_anchor      = oq_rdata.anch;
endmodule

// ===== sv/plcg_fifo.sv =====
// ----------------------------------------------------------------------------
// plcg_fifo: small register queue
// Power-of-two depth, read data shown at the head, occupancy count out.
// ----------------------------------------------------------------------------
module plcg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic             do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign rdata  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      count <= count + ($clog2(DEPTH+1))'(push) - ($clog2(DEPTH+1))'(do_pop);
    end
  end
endmodule

// ===== sv/plcg_front.sv =====
// ----------------------------------------------------------------------------
// plcg_front: link vector and squared length
// Three stages: difference, magnitude and square, sum of squares.
// ----------------------------------------------------------------------------
module plcg_front (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     push,
  output logic                                     full,
  input  logic [7:0]                               link_tag,
  input  logic signed [30:0]                       first_x,
  input  logic signed [30:0]                       first_y,
  input  logic signed [30:0]                       first_z,
  input  logic signed [30:0]                       second_x,
  input  logic signed [30:0]                       second_y,
  input  logic signed [30:0]                       second_z,
  input  logic                                     anchored,
  input  logic signed [30:0]                       anchor_x,
  input  logic signed [30:0]                       anchor_y,
  input  logic signed [30:0]                       anchor_z,
  input  logic [$clog2(plcg_pkg::MQ_DEPTH+1)-1:0]  mq_count,
  output logic                                     beat_valid,
  output plcg_pkg::front_beat_t                    beat
);
  localparam int CW = $clog2(plcg_pkg::MQ_DEPTH+1) + 1;

  logic               v1, v2;
  logic [7:0]         tag1, tag2;
  logic signed [31:0] dx, dy, dz;
  logic [31:0]        mx2, my2, mz2;
  logic               sx2, sy2, sz2;
  logic [63:0]        qx, qy, qz;
  logic               take;
  logic [30:0]        ex, ey, ez;
  logic [CW-1:0]      used;

  // room is reserved for every beat still in the three stages
  assign used = CW'(mq_count) + CW'(v1) + CW'(v2) + CW'(beat_valid);
  assign full = (used >= CW'(plcg_pkg::MQ_DEPTH));
  assign take = push && !full;

  assign ex = anchored ? anchor_x : second_x;
  assign ey = anchored ? anchor_y : second_y;
  assign ez = anchored ? anchor_z : second_z;

  always_ff @(posedge clk) begin
    tag1 <= link_tag;
    dx   <= {ex[30], ex} - {first_x[30], first_x};
    dy   <= {ey[30], ey} - {first_y[30], first_y};
    dz   <= {ez[30], ez} - {first_z[30], first_z};

    tag2 <= tag1;
    sx2  <= dx[31];
    sy2  <= dy[31];
    sz2  <= dz[31];
    mx2  <= dx[31] ? 32'(-dx) : 32'(dx);
    my2  <= dy[31] ? 32'(-dy) : 32'(dy);
    mz2  <= dz[31] ? 32'(-dz) : 32'(dz);
    qx   <= (dx[31] ? 64'(32'(-dx)) : 64'(32'(dx))) * (dx[31] ? 64'(32'(-dx)) : 64'(32'(dx)));
    qy   <= (dy[31] ? 64'(32'(-dy)) : 64'(32'(dy))) * (dy[31] ? 64'(32'(-dy)) : 64'(32'(dy)));
    qz   <= (dz[31] ? 64'(32'(-dz)) : 64'(32'(dz))) * (dz[31] ? 64'(32'(-dz)) : 64'(32'(dz)));

    beat.tag <= tag2;
    beat.mx  <= mx2;
    beat.my  <= my2;
    beat.mz  <= mz2;
    beat.sx  <= sx2;
    beat.sy  <= sy2;
    beat.sz  <= sz2;
    beat.sum <= qx + qy + qz;

    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      beat_valid <= 1'b0;
    end else begin
      v1         <= take;
      v2         <= v1;
      beat_valid <= v2;
    end
  end
endmodule

// ===== sv/plcg_back.sv =====
// ----------------------------------------------------------------------------
// plcg_back: square root, contact test and normal division
// Issues from the middle queue only when the result queue has a slot reserved.
// ----------------------------------------------------------------------------
module plcg_back (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     mq_empty,
  input  plcg_pkg::front_beat_t                    mq_data,
  output logic                                     mq_pop,
  input  logic [$clog2(plcg_pkg::OQ_DEPTH+1)-1:0]  oq_count,
  output logic                                     oq_push,
  output plcg_pkg::result_t                        oq_data,
  input  logic                                     link_kind,
  input  logic                                     anchored,
  input  logic [31:0]                              link_length,
  input  logic [15:0]                              bounce_factor
);
  localparam int NS = plcg_pkg::SQRT_STAGES;
  localparam int ND = plcg_pkg::DIV_STAGES;
  localparam int CW = $clog2(plcg_pkg::OQ_DEPTH+1) + 1;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] mx;
    logic [31:0] my;
    logic [31:0] mz;
    logic        sx;
    logic        sy;
    logic        sz;
  } carry_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic        hit;
    logic        zero;
    logic        nx;
    logic        ny;
    logic        nz;
    logic [31:0] depth;
    logic [31:0] d;
  } dcarry_t;

  logic [NS:0]          sv;
  carry_t               sc [NS+1];
  plcg_pkg::sqrt_st_t   ss [NS+1];
  logic [ND:0]          dv;
  dcarry_t              dc [ND+1];
  plcg_pkg::div_st_t    lx [ND+1];
  plcg_pkg::div_st_t    ly [ND+1];
  plcg_pkg::div_st_t    lz [ND+1];
  logic [CW-1:0]        inflight;
  logic                 issue;
  logic [31:0]          len;
  logic                 rod;
  logic                 hit;
  logic                 flip;
  logic                 leave;

  assign issue  = !mq_empty && ((CW'(oq_count) + inflight) < CW'(plcg_pkg::OQ_DEPTH));
  assign mq_pop = issue;
  assign leave  = dv[ND];

  // contact decision on the finished root
  assign len  = ss[NS].root;
  assign rod  = link_kind;
  assign hit  = rod ? (len != link_length) : (len >= link_length);
  assign flip = rod && (len < link_length);

  always_ff @(posedge clk) begin
    sc[0] <= '{tag: mq_data.tag, mx: mq_data.mx, my: mq_data.my, mz: mq_data.mz,
               sx: mq_data.sx, sy: mq_data.sy, sz: mq_data.sz};
    ss[0] <= '{rad: mq_data.sum, rem: '0, root: '0};
    for (int k = 1; k <= NS; k++) begin
      sc[k] <= sc[k-1];
      ss[k] <= plcg_pkg::sqrt_step2(ss[k-1]);
    end

    dc[0].tag   <= sc[NS].tag;
    dc[0].hit   <= hit;
    dc[0].zero  <= (len == '0);
    dc[0].nx    <= sc[NS].sx ^ flip;
    dc[0].ny    <= sc[NS].sy ^ flip;
    dc[0].nz    <= sc[NS].sz ^ flip;
    dc[0].depth <= (len > link_length) ? (len - link_length) : (link_length - len);
    dc[0].d     <= len;
    lx[0] <= '{r: {2'b00, sc[NS].mx, 14'h0} + {17'h0, len[31:1]}, q: '0};
    ly[0] <= '{r: {2'b00, sc[NS].my, 14'h0} + {17'h0, len[31:1]}, q: '0};
    lz[0] <= '{r: {2'b00, sc[NS].mz, 14'h0} + {17'h0, len[31:1]}, q: '0};
    for (int j = 1; j <= ND; j++) begin
      dc[j] <= dc[j-1];
      lx[j] <= plcg_pkg::div_step2(lx[j-1], dc[j-1].d, 17 - 2*j);
      ly[j] <= plcg_pkg::div_step2(ly[j-1], dc[j-1].d, 17 - 2*j);
      lz[j] <= plcg_pkg::div_step2(lz[j-1], dc[j-1].d, 17 - 2*j);
    end

    if (rst) begin
      sv       <= '0;
      dv       <= '0;
      inflight <= '0;
    end else begin
      sv       <= {sv[NS-1:0], issue};
      dv       <= {dv[ND-1:0], sv[NS]};
      inflight <= inflight + CW'(issue) - CW'(leave);
    end
  end

  assign oq_push       = dv[ND] && dc[ND].hit;
  assign oq_data.tag   = dc[ND].tag;
  assign oq_data.nx    = plcg_pkg::finish_comp(lx[ND].q, dc[ND].nx, dc[ND].zero);
  assign oq_data.ny    = plcg_pkg::finish_comp(ly[ND].q, dc[ND].ny, dc[ND].zero);
  assign oq_data.nz    = plcg_pkg::finish_comp(lz[ND].q, dc[ND].nz, dc[ND].zero);
  assign oq_data.depth = dc[ND].depth;
  assign oq_data.rest  = link_kind ? 16'h0 : bounce_factor;
  assign oq_data.anch  = anchored;
endmodule
